// ----- hdl/npic_pkg.sv -----
// Shared constants, types and helper functions of the interrupt collector.
package npic_pkg;

   localparam int NUM_SOURCES = 128;
   localparam int NUM_LEVELS  = 4;
   localparam int IDX_W       = 7;
   localparam int PRIO_W      = 2;
   localparam int LVL_W       = $clog2(NUM_LEVELS);
   localparam int TREE_SIZE   = 128;
   localparam int GROUP       = 8;
   localparam int NUM_GRP_A   = TREE_SIZE / GROUP;
   localparam int NUM_GRP_B   = NUM_GRP_A / GROUP;

   // operation codes
   localparam logic [1:0] OP_LINE  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   // write aliases
   localparam logic [1:0] ALIAS_PLAIN  = 2'd0;
   localparam logic [1:0] ALIAS_SET    = 2'd1;
   localparam logic [1:0] ALIAS_CLEAR  = 2'd2;
   localparam logic [1:0] ALIAS_TOGGLE = 2'd3;

   // register map
   localparam logic [8:0] REG_VECTOR   = 9'h000;
   localparam logic [8:0] REG_LEVELACK = 9'h001;
   localparam logic [8:0] REG_CTRL     = 9'h002;
   localparam logic [8:0] REG_VBASE    = 9'h004;
   localparam logic [8:0] REG_STAT     = 9'h007;
   localparam logic [8:0] REG_RAW0     = 9'h00a;
   localparam logic [8:0] REG_RAW1     = 9'h00b;
   localparam logic [8:0] REG_RAW2     = 9'h00c;
   localparam logic [8:0] REG_RAW3     = 9'h00d;
   localparam logic [8:0] REG_INTR0    = 9'h012;
   localparam logic [8:0] REG_INTR_END = 9'(REG_INTR0 + NUM_SOURCES);
   localparam logic [8:0] REG_UNDEF    = 9'h0f2;
   localparam logic [8:0] REG_VERSION  = 9'h0f3;

   localparam logic [31:0] VERSION_VALUE = 32'h0200_0000;
   localparam logic [31:0] STAT_NONE     = 32'h0000_007f;
   localparam logic [31:0] CTRL_RESET    = 32'hc000_0000;
   localparam logic [3:0]  LEVEL_MASK    = 4'hf;

   // control word bits
   localparam int CTRL_SOFTRST = 31;
   localparam int CTRL_GATE    = 30;
   localparam int CTRL_NONEST  = 19;
   localparam int CTRL_RSE     = 18;
   localparam int CTRL_FIQEN   = 17;
   localparam int CTRL_IRQEN   = 16;

   // source control bits
   localparam int SRC_EN   = 2;
   localparam int SRC_SOFT = 3;
   localparam int SRC_FIQ  = 4;

   typedef struct packed {
      logic              valid;
      logic [PRIO_W-1:0] prio;
      logic [IDX_W-1:0]  idx;
   } cand_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic mem_fin;
      logic tree_a;
      logic tree_b;
      logic tree_c;
   } cmd_type;

   typedef struct packed {
      logic is_intr;
      logic needs_update;
   } status_type;

   // keep a unless b has strictly higher priority (lower index wins ties)
   function automatic cand_type cand_pick(cand_type a, cand_type b);
      return (b.valid && (!a.valid || (b.prio > a.prio))) ? b : a;
   endfunction

   function automatic logic [31:0] apply_alias(logic [31:0] old, logic [31:0] v,
                                               logic [1:0] alias_sel);
      logic [31:0] r;
      case (alias_sel)
         ALIAS_SET:    r = old | v;
         ALIAS_CLEAR:  r = old & ~v;
         ALIAS_TOGGLE: r = old ^ v;
         default:      r = v;
      endcase
      return r;
   endfunction

endpackage

// ----- hdl/npic_req_if.sv -----
// Request channel interface: handshake plus item fields.
interface npic_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [6:0]  line_index;
   logic        line_level;
   logic [8:0]  reg_index;
   logic [1:0]  alias_req;
   logic [31:0] write_data;

   modport source (output valid, operation, line_index, line_level, reg_index,
                   alias_req, write_data, input ready);
   modport sink (input valid, operation, line_index, line_level, reg_index,
                 alias_req, write_data, output ready);
endinterface

// ----- hdl/npic_rsp_if.sv -----
// Response channel interface: handshake plus result fields.
interface npic_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;
   logic        irq_line;
   logic        fiq_line;
   logic        presented_valid;
   logic [6:0]  presented_source;

   modport source (output valid, read_data, irq_line, fiq_line, presented_valid,
                   presented_source, input ready);
   modport sink (input valid, read_data, irq_line, fiq_line, presented_valid,
                 presented_source, output ready);
endinterface

// ----- hdl/nested_priority_interrupt_collector_core.sv -----
// Top level of the nested priority interrupt collector.
//
//   channel   direction  handshake            payload
//   req_if    in         valid/ready          operation, line, register access
//   rsp_if    out        valid/ready          read data, irq, fiq, presented source
//
// One transfer at a time. A read or write of other registers goes from acceptance
// through the execute state to the response; a source control access adds a memory
// read state; any item that updates state adds the update states A, B and C of the
// registered priority search tree over 128 sources. The response may then stall.
// Reset is synchronous; no clearing pass is needed.
// The request side stays not ready while a response waits to be taken.
module nested_priority_interrupt_collector_core (
   input logic       clock,
   input logic       reset,
   npic_req_if.sink  req_if,
   npic_rsp_if.source rsp_if
);
   import npic_pkg::*;

   cmd_type    cmd;
   status_type status;

   npic_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   npic_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .in_operation    (req_if.operation),
      .in_line_index   (req_if.line_index),
      .in_line_level   (req_if.line_level),
      .in_reg_index    (req_if.reg_index),
      .in_alias_req    (req_if.alias_req),
      .in_write_data   (req_if.write_data),
      .out_read_data   (rsp_if.read_data),
      .out_irq         (rsp_if.irq_line),
      .out_fiq         (rsp_if.fiq_line),
      .out_pres_valid  (rsp_if.presented_valid),
      .out_pres_source (rsp_if.presented_source)
   );
endmodule

// ----- hdl/npic_ctrl.sv -----
// Sequencer: steps one transfer through execute, memory, update and response.
module npic_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  npic_pkg::status_type status,
   output npic_pkg::cmd_type    cmd
);
   import npic_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_EXEC, ST_MEMF, ST_UPDA, ST_UPDB, ST_UPDC, ST_RESP
   } state_type;

   state_type state_ff;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: if (req_valid) state_ff <= ST_EXEC;
            ST_EXEC: begin
               if (status.is_intr) state_ff <= ST_MEMF;
               else if (status.needs_update) state_ff <= ST_UPDA;
               else state_ff <= ST_RESP;
            end
            ST_MEMF: state_ff <= status.needs_update ? ST_UPDA : ST_RESP;
            ST_UPDA: state_ff <= ST_UPDB;
            ST_UPDB: state_ff <= ST_UPDC;
            ST_UPDC: state_ff <= ST_RESP;
            ST_RESP: if (rsp_ready) state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // commands to the datapath
   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = (state_ff == ST_RESP);
   assign cmd.load    = (state_ff == ST_IDLE) && req_valid;
   assign cmd.exec    = (state_ff == ST_EXEC);
   assign cmd.mem_fin = (state_ff == ST_MEMF);
   assign cmd.tree_a  = (state_ff == ST_UPDA);
   assign cmd.tree_b  = (state_ff == ST_UPDB);
   assign cmd.tree_c  = (state_ff == ST_UPDC);
endmodule

// ----- hdl/npic_dp.sv -----
// Datapath: source state, control memory, registers and priority search tree.
module npic_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  npic_pkg::cmd_type        cmd,
   output npic_pkg::status_type     status,
   input  logic [1:0]               in_operation,
   input  logic [6:0]               in_line_index,
   input  logic                     in_line_level,
   input  logic [8:0]               in_reg_index,
   input  logic [1:0]               in_alias_req,
   input  logic [31:0]              in_write_data,
   output logic [31:0]              out_read_data,
   output logic                     out_irq,
   output logic                     out_fiq,
   output logic                     out_pres_valid,
   output logic [6:0]               out_pres_source
);
   import npic_pkg::*;

   // item registers
   logic [1:0]  op_ff;
   logic [6:0]  line_ff;
   logic        lvl_ff;
   logic [8:0]  idx_ff;
   logic [1:0]  alias_ff;
   logic [31:0] data_ff;

   // source state
   logic [NUM_SOURCES-1:0] raw_ff;
   logic [NUM_SOURCES-1:0] en_ff;
   logic [NUM_SOURCES-1:0] soft_ff;
   logic [NUM_SOURCES-1:0] fiq_ff;
   logic [NUM_SOURCES-1:0] mvalid_ff;
   logic [PRIO_W-1:0]      prio_ff [NUM_SOURCES];
   logic [31:0]            mem [NUM_SOURCES];
   logic [31:0]            mem_q_ff;

   // global registers
   logic [31:0]           ctrl_ff;
   logic [31:0]           vbase_ff;
   logic [31:0]           undef_ff;
   logic [NUM_LEVELS-1:0] lis_ff;
   logic [IDX_W-1:0]      lsrc_ff [NUM_LEVELS];
   logic                  pres_ok_ff;
   logic [IDX_W-1:0]      pres_ff;
   logic [PRIO_W-1:0]     pprio_ff;
   logic                  irq_ff;
   logic                  fiq_out_ff;
   logic [31:0]           rd_ff;

   // tree registers
   cand_type grp_a_ff [NUM_GRP_A];
   logic     fiqa_ff  [NUM_GRP_A];
   cand_type grp_b_ff [NUM_GRP_B];
   logic     fiqb_ff;

   // combinational helpers
   logic [8:0]            intr_off;
   logic                  intr_hit;
   logic [IDX_W-1:0]      intr_n;
   logic                  top_ok;
   logic [LVL_W-1:0]      top_idx;
   logic [31:0]           ctrl_new;
   logic                  srst;
   logic [TREE_SIZE-1:0]  raw_pad;
   logic [1:0]            raw_sel;
   logic [31:0]           raw_word;
   logic [31:0]           vec_value;
   logic [31:0]           rd_exec;
   logic [31:0]           intr_old;
   logic [31:0]           intr_new;
   logic                  line_ok;
   logic [NUM_SOURCES-1:0] keep;
   cand_type              leaf [TREE_SIZE];
   logic                  leaf_fiq [TREE_SIZE];
   cand_type              grp_a [NUM_GRP_A];
   logic                  fiqa [NUM_GRP_A];
   cand_type              grp_b [NUM_GRP_B];
   logic                  fiqb;
   cand_type              final_c;

   // decode of the held item
   always_comb begin
      intr_off = idx_ff - REG_INTR0;
      intr_hit = (idx_ff >= REG_INTR0) && (idx_ff < REG_INTR_END);
      intr_n   = intr_off[IDX_W-1:0];
      line_ok  = ({1'b0, line_ff} < 8'(NUM_SOURCES));
      ctrl_new = apply_alias(ctrl_ff, data_ff, alias_ff);
      srst     = ctrl_new[CTRL_SOFTRST] && !ctrl_ff[CTRL_SOFTRST];
      intr_old = mvalid_ff[intr_n] ? mem_q_ff : 32'd0;
      intr_new = apply_alias(intr_old, data_ff, alias_ff);
      raw_pad  = TREE_SIZE'(raw_ff);
      raw_sel  = idx_ff[1:0] - 2'd2;
      raw_word = raw_pad[{raw_sel, 5'd0} +: 32];
   end

   // highest in-service level
   always_comb begin
      top_ok  = 1'b0;
      top_idx = '0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
         if (lis_ff[l]) begin
            top_ok  = 1'b1;
            top_idx = LVL_W'(l);
         end
      end
   end

   // register read value
   always_comb begin
      if (pres_ok_ff) vec_value = vbase_ff + {23'd0, pres_ff, 2'b00};
      else if (undef_ff != 32'd0) vec_value = undef_ff;
      else vec_value = vbase_ff;
      case (idx_ff)
         REG_VECTOR:  rd_exec = vec_value;
         REG_CTRL:    rd_exec = ctrl_ff;
         REG_VBASE:   rd_exec = vbase_ff;
         REG_STAT:    rd_exec = pres_ok_ff ? {25'd0, pres_ff} : STAT_NONE;
         REG_RAW0:    rd_exec = raw_word;
         REG_RAW1:    rd_exec = raw_word;
         REG_RAW2:    rd_exec = raw_word;
         REG_RAW3:    rd_exec = raw_word;
         REG_UNDEF:   rd_exec = undef_ff;
         REG_VERSION: rd_exec = VERSION_VALUE;
         default:     rd_exec = 32'd0;
      endcase
   end

   // status to the sequencer
   always_comb begin
      status.is_intr = ((op_ff == OP_READ) || (op_ff == OP_WRITE)) && intr_hit;
      case (op_ff)
         OP_LINE:  status.needs_update = line_ok;
         OP_READ:  status.needs_update = (idx_ff == REG_VECTOR) && pres_ok_ff
                                         && ctrl_ff[CTRL_RSE];
         OP_WRITE: status.needs_update = (idx_ff == REG_VECTOR) ||
                                         (idx_ff == REG_LEVELACK) ||
                                         (idx_ff == REG_CTRL) || intr_hit;
         default:  status.needs_update = 1'b0;
      endcase
   end

   // leaves: per-source candidates and the keep test for in-service levels
   always_comb begin
      keep = soft_ff | (en_ff & raw_ff);
      for (int i = 0; i < TREE_SIZE; i++) begin
         leaf[i]     = '0;
         leaf_fiq[i] = 1'b0;
         if (i < NUM_SOURCES) begin
            leaf[i].valid = en_ff[i] && (soft_ff[i] || raw_ff[i]) && !fiq_ff[i];
            leaf[i].prio  = prio_ff[i];
            leaf[i].idx   = IDX_W'(i);
            leaf_fiq[i]   = en_ff[i] && (soft_ff[i] || raw_ff[i]) && fiq_ff[i];
         end
      end
   end

   // tree stage A: groups of eight sources
   always_comb begin
      for (int g = 0; g < NUM_GRP_A; g++) begin
         grp_a[g] = '0;
         fiqa[g]  = 1'b0;
         for (int k = 0; k < GROUP; k++) begin
            grp_a[g] = cand_pick(grp_a[g], leaf[g*GROUP+k]);
            fiqa[g]  = fiqa[g] | leaf_fiq[g*GROUP+k];
         end
      end
   end

   // tree stage B and final pick
   always_comb begin
      fiqb = 1'b0;
      for (int g = 0; g < NUM_GRP_B; g++) begin
         grp_b[g] = '0;
         for (int k = 0; k < GROUP; k++) begin
            grp_b[g] = cand_pick(grp_b[g], grp_a_ff[g*GROUP+k]);
            fiqb     = fiqb | fiqa_ff[g*GROUP+k];
         end
      end
      final_c = '0;
      for (int g = 0; g < NUM_GRP_B; g++) begin
         final_c = cand_pick(final_c, grp_b_ff[g]);
      end
   end

   // control word memory, read every cycle at the held index
   always_ff @(posedge clock) begin
      if (cmd.mem_fin && (op_ff == OP_WRITE)) mem[intr_n] <= intr_new;
      mem_q_ff <= mem[intr_n];
   end

   // item capture and tree registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= in_operation;
         line_ff  <= in_line_index;
         lvl_ff   <= in_line_level;
         idx_ff   <= in_reg_index;
         alias_ff <= in_alias_req;
         data_ff  <= in_write_data;
      end
      if (cmd.tree_a) begin
         grp_a_ff <= grp_a;
         fiqa_ff  <= fiqa;
      end
      if (cmd.tree_b) begin
         grp_b_ff <= grp_b;
         fiqb_ff  <= fiqb;
      end
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff     <= '0;
         en_ff      <= '0;
         soft_ff    <= '0;
         fiq_ff     <= '0;
         mvalid_ff  <= '0;
         for (int i = 0; i < NUM_SOURCES; i++) prio_ff[i] <= '0;
         ctrl_ff    <= CTRL_RESET;
         vbase_ff   <= '0;
         undef_ff   <= '0;
         lis_ff     <= '0;
         for (int l = 0; l < NUM_LEVELS; l++) lsrc_ff[l] <= '0;
         pres_ok_ff <= 1'b0;
         pres_ff    <= '0;
         pprio_ff   <= '0;
         irq_ff     <= 1'b0;
         fiq_out_ff <= 1'b0;
         rd_ff      <= '0;
      end else begin
         if (cmd.load) rd_ff <= '0;

         // execute the item
         if (cmd.exec) begin
            case (op_ff)
               OP_LINE: begin
                  if (line_ok) raw_ff[line_ff] <= lvl_ff;
               end
               OP_READ: begin
                  if (!intr_hit) begin
                     rd_ff <= rd_exec;
                     // vector read pushes the presented level
                     if ((idx_ff == REG_VECTOR) && pres_ok_ff && ctrl_ff[CTRL_RSE]) begin
                        lis_ff[pprio_ff]  <= 1'b1;
                        lsrc_ff[pprio_ff] <= pres_ff;
                     end
                  end
               end
               OP_WRITE: begin
                  case (idx_ff)
                     REG_VECTOR: if (top_ok) lis_ff[top_idx] <= 1'b0;
                     REG_LEVELACK: lis_ff <= lis_ff & ~(data_ff[3:0] & LEVEL_MASK);
                     REG_CTRL: begin
                        // soft reset also sets the clock gate bit
                        ctrl_ff <= srst ? (ctrl_new | (32'd1 << CTRL_GATE)) : ctrl_new;
                        if (srst) begin
                           en_ff     <= '0;
                           soft_ff   <= '0;
                           fiq_ff    <= '0;
                           mvalid_ff <= '0;
                           for (int i = 0; i < NUM_SOURCES; i++) prio_ff[i] <= '0;
                           lis_ff    <= '0;
                        end
                     end
                     REG_VBASE: vbase_ff <= apply_alias(vbase_ff, data_ff, alias_ff);
                     REG_UNDEF: undef_ff <= apply_alias(undef_ff, data_ff, alias_ff);
                     default: ;
                  endcase
               end
               default: ;
            endcase
         end

         // finish a source control access
         if (cmd.mem_fin) begin
            if (op_ff == OP_WRITE) begin
               mvalid_ff[intr_n] <= 1'b1;
               en_ff[intr_n]     <= intr_new[SRC_EN];
               soft_ff[intr_n]   <= intr_new[SRC_SOFT];
               fiq_ff[intr_n]    <= intr_new[SRC_FIQ];
               prio_ff[intr_n]   <= intr_new[PRIO_W-1:0];
            end else begin
               rd_ff <= intr_old;
            end
         end

         // release levels whose source went away
         if (cmd.tree_a) begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
               if (lis_ff[l] && !keep[lsrc_ff[l]]) lis_ff[l] <= 1'b0;
            end
         end

         // present the winner and drive the outputs
         if (cmd.tree_c) begin
            pres_ok_ff <= final_c.valid;
            pres_ff    <= final_c.valid ? final_c.idx : '0;
            pprio_ff   <= final_c.prio;
            irq_ff     <= final_c.valid && ctrl_ff[CTRL_IRQEN] &&
                          (!top_ok || (!ctrl_ff[CTRL_NONEST] &&
                                       (final_c.prio > top_idx)));
            fiq_out_ff <= fiqb_ff && ctrl_ff[CTRL_FIQEN];
         end
      end
   end

   assign out_read_data   = rd_ff;
   assign out_irq         = irq_ff;
   assign out_fiq         = fiq_out_ff;
   assign out_pres_valid  = pres_ok_ff;
   assign out_pres_source = pres_ff;
endmodule

// ----- bench/nested_priority_interrupt_collector_core_test.sv -----
// Self-checking testbench of the nested priority interrupt collector core.
module nested_priority_interrupt_collector_core_test;
   import npic_pkg::*;

   typedef struct {
      logic [31:0] read_data;
      logic        irq_line;
      logic        fiq_line;
      logic        presented_valid;
      logic [6:0]  presented_source;
   } outcome_t;

   logic clock;
   logic reset;

   npic_req_if req_if ();
   npic_rsp_if rsp_if ();

   nested_priority_interrupt_collector_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   // predictor state
   logic [NUM_SOURCES-1:0] line_raw;
   logic [31:0]            src_ctl [NUM_SOURCES];
   logic [31:0]            ctl_word;
   logic [31:0]            vec_base;
   logic [31:0]            undef_vec;
   logic [NUM_LEVELS-1:0]  in_service;
   logic [NUM_LEVELS-1:0]  lvl_valid;
   logic [6:0]             lvl_src [NUM_LEVELS];
   logic                   pres_ok;
   logic [6:0]             pres_src;
   logic                   irq_q;
   logic                   fiq_q;

   outcome_t expected_outcomes [$];
   int       mismatch_count;
   int       idle_cycles;
   int       hold_off;
   bit       rsp_random_stall;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit src_asserted(int n);
      if (!src_ctl[n][SRC_EN]) return 1'b0;
      return src_ctl[n][SRC_SOFT] || line_raw[n];
   endfunction

   function automatic int pick_source(bit want_fiq);
      int best;
      int best_p;
      best = -1;
      best_p = -1;
      for (int i = 0; i < NUM_SOURCES; i++) begin
         if (src_asserted(i) && (src_ctl[i][SRC_FIQ] == want_fiq)
               && int'(src_ctl[i][1:0]) > best_p) begin
            best_p = int'(src_ctl[i][1:0]);
            best = i;
         end
      end
      return best;
   endfunction

   function automatic int top_in_service();
      for (int l = NUM_LEVELS - 1; l >= 0; l--)
         if (in_service[l]) return l;
      return -1;
   endfunction

   function automatic void release_level(int l);
      in_service[l] = 1'b0;
      lvl_valid[l] = 1'b0;
      lvl_src[l] = '0;
   endfunction

   // retire vanished levels, then recompute presentation and outputs
   function automatic void refresh_outputs();
      int irq_src;
      int fiq_src;
      int top;
      int s;
      for (int l = 0; l < NUM_LEVELS; l++) begin
         if (in_service[l] && lvl_valid[l]) begin
            s = int'(lvl_src[l]);
            if (!src_asserted(s) && !src_ctl[s][SRC_SOFT]) release_level(l);
         end
      end
      irq_src = pick_source(1'b0);
      fiq_src = pick_source(1'b1);
      top = top_in_service();
      pres_ok = irq_src >= 0;
      pres_src = pres_ok ? 7'(irq_src) : '0;
      irq_q = 1'b0;
      if (pres_ok && ctl_word[CTRL_IRQEN]) begin
         if (top < 0) irq_q = 1'b1;
         else if (!ctl_word[CTRL_NONEST] && int'(src_ctl[irq_src][1:0]) > top)
            irq_q = 1'b1;
      end
      fiq_q = fiq_src >= 0 && ctl_word[CTRL_FIQEN];
   endfunction

   function automatic logic [31:0] merge_alias(logic [31:0] old, logic [31:0] v,
                                               logic [1:0] sel);
      case (sel)
         ALIAS_SET:    return old | v;
         ALIAS_CLEAR:  return old & ~v;
         ALIAS_TOGGLE: return old ^ v;
         default:      return v;
      endcase
   endfunction

   function automatic logic [31:0] predict_read(logic [8:0] idx);
      logic [31:0] v;
      int p;
      if (idx >= REG_INTR0 && idx < REG_INTR_END) return src_ctl[idx - REG_INTR0];
      case (idx)
         REG_VECTOR: begin
            if (!pres_ok) return (undef_vec != 0) ? undef_vec : vec_base;
            v = vec_base + {23'd0, pres_src, 2'b00};
            if (ctl_word[CTRL_RSE]) begin
               p = int'(src_ctl[pres_src][1:0]);
               in_service[p] = 1'b1;
               lvl_valid[p] = 1'b1;
               lvl_src[p] = pres_src;
               refresh_outputs();
            end
            return v;
         end
         REG_CTRL:    return ctl_word;
         REG_VBASE:   return vec_base;
         REG_STAT:    return pres_ok ? {25'd0, pres_src} : STAT_NONE;
         REG_RAW0:    return line_raw[31:0];
         REG_RAW1:    return line_raw[63:32];
         REG_RAW2:    return line_raw[95:64];
         REG_RAW3:    return line_raw[127:96];
         REG_UNDEF:   return undef_vec;
         REG_VERSION: return VERSION_VALUE;
         default:     return '0;
      endcase
   endfunction

   function automatic void predict_write(logic [8:0] idx, logic [1:0] sel,
                                         logic [31:0] v);
      logic [31:0] old;
      int l;
      if (idx >= REG_INTR0 && idx < REG_INTR_END) begin
         src_ctl[idx - REG_INTR0] = merge_alias(src_ctl[idx - REG_INTR0], v, sel);
         refresh_outputs();
         return;
      end
      case (idx)
         REG_VECTOR: begin
            l = top_in_service();
            if (l >= 0) release_level(l);
            refresh_outputs();
         end
         REG_LEVELACK: begin
            for (int k = 0; k < NUM_LEVELS; k++)
               if (v[k]) release_level(k);
            refresh_outputs();
         end
         REG_CTRL: begin
            old = ctl_word;
            ctl_word = merge_alias(old, v, sel);
            // soft reset on a rising bit 31
            if (ctl_word[CTRL_SOFTRST] && !old[CTRL_SOFTRST]) begin
               ctl_word[CTRL_GATE] = 1'b1;
               for (int n = 0; n < NUM_SOURCES; n++) src_ctl[n] = '0;
               for (int k = 0; k < NUM_LEVELS; k++) release_level(k);
            end
            refresh_outputs();
         end
         REG_VBASE: vec_base = merge_alias(vec_base, v, sel);
         REG_UNDEF: undef_vec = merge_alias(undef_vec, v, sel);
         default: ;
      endcase
   endfunction

   // step the predictor over one accepted item
   function automatic outcome_t collector_step(logic [1:0] op, logic [6:0] line,
         logic lvl, logic [8:0] idx, logic [1:0] sel, logic [31:0] data);
      outcome_t o;
      o.read_data = '0;
      if (op == OP_LINE) begin
         line_raw[line] = lvl;
         refresh_outputs();
      end else if (op == OP_READ) begin
         o.read_data = predict_read(idx);
      end else if (op == OP_WRITE) begin
         predict_write(idx, sel, data);
      end
      o.irq_line = irq_q;
      o.fiq_line = fiq_q;
      o.presented_valid = pres_ok;
      o.presented_source = pres_ok ? pres_src : '0;
      return o;
   endfunction

   function automatic void collector_reset();
      line_raw = '0;
      for (int n = 0; n < NUM_SOURCES; n++) src_ctl[n] = '0;
      ctl_word = CTRL_RESET;
      vec_base = '0;
      undef_vec = '0;
      in_service = '0;
      lvl_valid = '0;
      for (int l = 0; l < NUM_LEVELS; l++) lvl_src[l] = '0;
      pres_ok = 1'b0;
      pres_src = '0;
      irq_q = 1'b0;
      fiq_q = 1'b0;
   endfunction

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // send one item; prediction is made at the accepting edge
   task automatic send_item(logic [1:0] op, logic [6:0] line, logic lvl,
                            logic [8:0] idx, logic [1:0] sel, logic [31:0] data,
                            bit no_gap = 1'b0);
      int gap;
      gap = no_gap ? 0 : gap_length();
      // step past the previous transfer first, so valid drops before it rises
      repeat (gap + 1) @(posedge clock);
      req_if.valid <= 1'b1;
      req_if.operation <= op;
      req_if.line_index <= line;
      req_if.line_level <= lvl;
      req_if.reg_index <= idx;
      req_if.alias_req <= sel;
      req_if.write_data <= data;
      do @(posedge clock); while (!req_if.ready);
      expected_outcomes.push_back(collector_step(op, line, lvl, idx, sel, data));
      req_if.valid <= 1'b0;
   endtask

   task automatic write_reg(logic [8:0] idx, logic [1:0] sel, logic [31:0] data);
      send_item(OP_WRITE, 7'($urandom), 1'($urandom), idx, sel, data);
   endtask

   task automatic read_reg(logic [8:0] idx);
      send_item(OP_READ, 7'($urandom), 1'($urandom), idx, 2'($urandom), $urandom);
   endtask

   task automatic set_line(int n, logic lvl);
      send_item(OP_LINE, 7'(n), lvl, 9'($urandom), 2'($urandom), $urandom);
   endtask

   task automatic wait_drained();
      while (expected_outcomes.size() != 0) @(posedge clock);
   endtask

   // response checker
   always @(posedge clock) begin
      outcome_t e;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_outcomes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected response transfer");
         end else begin
            e = expected_outcomes.pop_front();
            if (rsp_if.read_data !== e.read_data || rsp_if.irq_line !== e.irq_line
                  || rsp_if.fiq_line !== e.fiq_line
                  || rsp_if.presented_valid !== e.presented_valid
                  || rsp_if.presented_source !== e.presented_source) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("exp rd=%h irq=%b fiq=%b pv=%b ps=%0d got rd=%h irq=%b fiq=%b pv=%b ps=%0d",
                     e.read_data, e.irq_line, e.fiq_line, e.presented_valid,
                     e.presented_source, rsp_if.read_data, rsp_if.irq_line,
                     rsp_if.fiq_line, rsp_if.presented_valid, rsp_if.presented_source);
            end
         end
      end
   end

   // response ready: random stalls, or a counted hold-off
   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_off > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (hold_off) @(posedge clock);
            hold_off = 0;
         end
         stall = rsp_random_stall ? gap_length() : 0;
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // watchdog on cycles without any transfer
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= 20000) begin
            $display("nested_priority_interrupt_collector_core: mismatch");
            $finish;
         end
      end
   end

   task automatic test_registers();
      read_reg(REG_VERSION);
      read_reg(REG_CTRL);
      read_reg(REG_STAT);
      read_reg(REG_VECTOR);
      read_reg(9'h1ff);
      write_reg(9'h1ff, ALIAS_PLAIN, 32'hffff_ffff);
      write_reg(REG_VBASE, ALIAS_PLAIN, 32'hffff_ffff);
      write_reg(REG_VBASE, ALIAS_CLEAR, 32'h0000_ffff);
      write_reg(REG_UNDEF, ALIAS_SET, 32'h0000_0001);
      read_reg(REG_VECTOR);
      write_reg(REG_UNDEF, ALIAS_TOGGLE, 32'h0000_0001);
      read_reg(REG_VECTOR);
      read_reg(REG_UNDEF);
      write_reg(REG_CTRL, ALIAS_PLAIN, 32'h0007_0000);
      write_reg(REG_CTRL, ALIAS_SET, 32'h8000_0000);
      read_reg(REG_CTRL);
   endtask

   task automatic test_nesting();
      write_reg(REG_CTRL, ALIAS_PLAIN, 32'h0007_0000);
      write_reg(REG_INTR0, ALIAS_PLAIN, 32'h0000_0005);
      write_reg(9'(REG_INTR0 + 127), ALIAS_PLAIN, 32'h0000_0007);
      write_reg(9'(REG_INTR0 + 5), ALIAS_PLAIN, 32'h0000_0017);
      set_line(0, 1'b1);
      set_line(127, 1'b1);
      set_line(5, 1'b1);
      read_reg(REG_RAW0);
      read_reg(REG_RAW3);
      read_reg(REG_VECTOR);
      write_reg(9'(REG_INTR0 + 64), ALIAS_PLAIN, 32'h0000_000c);
      read_reg(REG_VECTOR);
      set_line(127, 1'b0);
      write_reg(REG_LEVELACK, ALIAS_TOGGLE, 32'hffff_fff1);
      write_reg(REG_VECTOR, ALIAS_SET, 32'h0);
      write_reg(REG_CTRL, ALIAS_SET, 32'h0008_0000);
      read_reg(REG_VECTOR);
      read_reg(REG_STAT);
   endtask

   task automatic test_random(int count);
      logic [1:0] op;
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 30) begin
            set_line($urandom_range(0, 127), 1'($urandom));
         end else if (r < 55) begin
            // mostly the low sources so that they interact
            write_reg(9'(REG_INTR0 + ($urandom_range(0, 3) == 0 ?
                      $urandom_range(0, 127) : $urandom_range(0, 7))),
                      2'($urandom), $urandom_range(0, 3) == 0 ? $urandom
                      : {27'd0, 5'($urandom)});
         end else if (r < 70) begin
            read_reg(REG_VECTOR);
         end else if (r < 78) begin
            write_reg($urandom_range(0, 1) ? REG_VECTOR : REG_LEVELACK,
                      2'($urandom), $urandom);
         end else if (r < 84) begin
            // control: mostly keep enables and read-side-effect mode on
            write_reg(REG_CTRL, 2'($urandom), $urandom_range(0, 3) == 0 ? $urandom
                      : ({$urandom} & 32'h800f_0000) | 32'h0007_0000);
         end else if (r < 88) begin
            write_reg($urandom_range(0, 1) ? REG_VBASE : REG_UNDEF, 2'($urandom),
                      $urandom);
         end else if (r < 98) begin
            read_reg($urandom_range(0, 3) == 0 ? 9'($urandom)
                     : 9'($urandom_range(0, 20)));
         end else begin
            op = 2'd3;
            send_item(op, 7'($urandom), 1'($urandom), 9'($urandom), 2'($urandom),
                      $urandom);
         end
      end
   endtask

   task automatic test_backpressure();
      hold_off = 300;
      for (int i = 0; i < 20; i++) set_line($urandom_range(0, 7), 1'($urandom));
      wait_drained();
      send_item(OP_READ, 7'd0, 1'b0, REG_STAT, ALIAS_PLAIN, 32'd0);
   endtask

   task automatic test_no_stall();
      rsp_random_stall = 1'b0;
      for (int i = 0; i < 60; i++)
         send_item(OP_READ, 7'd0, 1'b0, 9'($urandom_range(0, 20)), 2'($urandom),
                   32'd0, 1'b1);
      rsp_random_stall = 1'b1;
   endtask

   // main sequence
   initial begin
      mismatch_count = 0;
      hold_off = 0;
      rsp_random_stall = 1'b1;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.operation <= OP_LINE;
      req_if.line_index <= '0;
      req_if.line_level <= 1'b0;
      req_if.reg_index <= '0;
      req_if.alias_req <= ALIAS_PLAIN;
      req_if.write_data <= '0;
      collector_reset();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_registers();
      test_nesting();
      test_random(700);
      test_backpressure();
      test_no_stall();
      test_random(700);
      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_outcomes.size() == 0)
         $display("nested_priority_interrupt_collector_core: match");
      else
         $display("nested_priority_interrupt_collector_core: mismatch");
      $finish;
   end

endmodule
